@@ rtl/erkf_pkg.sv @@
// Shared widths, reset values and register codes for the echo range Kalman filter.
`timescale 1ns / 1ps

package erkf_pkg;

	localparam int TS_W   = 32;             // timestamp width
	localparam int TMO_W  = 16;             // timeout register width
	localparam int HGT_W  = 20;             // Q4.16 height width
	localparam int VAR_W  = 32;             // Q0.32 variance / gain width
	localparam int COS_W  = 16;             // Q1.14 cosine width
	localparam int TILT_W = HGT_W + 1;      // signed tilted height
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd30000;
	localparam logic [HGT_W-1:0] MAXH_RST    = 20'd327680;
	localparam logic [VAR_W-1:0] PVAR_RST    = 32'd429497;
	localparam logic [VAR_W-1:0] MVAR_RST    = 32'd10737418;

	localparam logic [HGT_W-1:0] HGT_MAX = '1;

	// 170 m/s one way in Q8.16 metres per microsecond, scaled by 1e6
	localparam int SPD_W = 24;
	localparam logic [SPD_W-1:0] SPEED_Q = 24'd11141120;
	localparam int NUM_W = TMO_W + SPD_W;
	localparam logic [NUM_W-1:0] Z_ROUND = 40'd500000;
	localparam logic [HGT_W-1:0] Z_DIV   = 20'd1000000;

	// |cos_roll * cos_pitch| is at most 2^30
	localparam int PM_W = 2 * COS_W - 1;
	// tilt product is formed as x * pm >> HGT_W, then shifted right by TILT_SH more bits with round half up
	localparam int TILT_SH = 28 - HGT_W;

	localparam int CNT_W = 5;
	localparam logic [CNT_W-1:0] K_LAST   = 5'd31;  // last gain / multiply step
	localparam logic [CNT_W-1:0] Z_STEPS  = 5'd20;  // height quotient bits
	localparam logic [CNT_W-1:0] PM_STEPS = 5'd16;  // cosine product steps
	localparam logic [CNT_W-1:0] T_LAST   = 5'd19;  // last tilt step

	typedef enum logic [1:0] {
		REG_TIMEOUT,
		REG_MAXH,
		REG_PVAR,
		REG_MVAR
	} reg_idx_t;

endpackage

@@ rtl/erkf_if.sv @@
// Valid/ready channel interfaces for echo edge items and height results.
`timescale 1ns / 1ps

interface erkf_echo_if;
	logic                               valid;
	logic                               ready;
	logic                               echo_level;
	logic [erkf_pkg::TS_W-1:0]          timestamp_us;
	logic signed [erkf_pkg::COS_W-1:0]  cos_roll;
	logic signed [erkf_pkg::COS_W-1:0]  cos_pitch;

	modport source (output valid, echo_level, timestamp_us, cos_roll, cos_pitch, input ready);
	modport sink   (input valid, echo_level, timestamp_us, cos_roll, cos_pitch, output ready);
endinterface

interface erkf_height_if;
	logic                               valid;
	logic                               ready;
	logic [erkf_pkg::HGT_W-1:0]         filtered_height;
	logic signed [erkf_pkg::TILT_W-1:0] tilted_height;
	logic                               out_of_range;

	modport source (output valid, filtered_height, tilted_height, out_of_range, input ready);
	modport sink   (input valid, filtered_height, tilted_height, out_of_range, output ready);
endinterface

@@ rtl/echo_range_kalman_filter_unit.sv @@
// Echo ranging height filter: pulse width to height, scalar Kalman filter, tilt correction.
//
// echo channel: one transfer per echo line edge (level, microsecond timestamp, two
// Q1.14 tilt cosines). A rising edge only records its timestamp; the block stays idle.
// A falling edge measures the pulse width, converts it to a Q4.16 height (or the
// configured maximum when the width exceeds the timeout), updates the estimate and
// variance, and produces one transfer on the height channel.
// A falling edge occupies the block from its transfer until the block takes the next
// item, passing in order through a set-up state, bit-serial gain division (the height
// quotient and the cosine product run alongside), a second set-up state, bit-serial
// estimate and variance multiplication, an update state, bit-serial tilt multiplication
// and the load of the result register.
// The result register parts the two channels: a waiting result does not stop new
// items; only the next result waits in its last cycle until the old one is taken.
// Configuration is written through the APB port (4-byte registers at 0, 4, 8, 12);
// the user must write it only while the block is idle; the block does not enforce this.
// Reset (arst_n low) clears the estimate, variance, stored rise time and the result
// valid, and restores the register defaults.
`timescale 1ns / 1ps

module echo_range_kalman_filter_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	erkf_echo_if.sink                     echo,
	erkf_height_if.source                 height,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [erkf_pkg::ADDR_W-1:0]   paddr,
	input  logic [erkf_pkg::DATA_W-1:0]   pwdata,
	output logic [erkf_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_SETUP,
		ST_MUL,
		ST_UPD,
		ST_TILT,
		ST_DONE
	} state_t;

	localparam int TS_W   = erkf_pkg::TS_W;
	localparam int TMO_W  = erkf_pkg::TMO_W;
	localparam int HGT_W  = erkf_pkg::HGT_W;
	localparam int VAR_W  = erkf_pkg::VAR_W;
	localparam int COS_W  = erkf_pkg::COS_W;
	localparam int TILT_W = erkf_pkg::TILT_W;
	localparam int NUM_W  = erkf_pkg::NUM_W;
	localparam int PM_W   = erkf_pkg::PM_W;
	localparam int CNT_W  = erkf_pkg::CNT_W;
	localparam int TR_W   = PM_W - erkf_pkg::TILT_SH + 1;

	// configuration registers
	logic [TMO_W-1:0] timeout_q;
	logic [HGT_W-1:0] maxh_q;
	logic [VAR_W-1:0] pvar_q;
	logic [VAR_W-1:0] mvar_q;

	// filter state
	logic [TS_W-1:0]  rise_q;
	logic [HGT_W-1:0] x_q;
	logic [VAR_W-1:0] var_q;

	// working registers
	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [TS_W-1:0]  width_q;
	logic [VAR_W-1:0] p1_q;
	logic [VAR_W:0]   den_q;
	logic             oor_q;
	logic [NUM_W-1:0] zn_q;
	logic [VAR_W:0]   rem_q;
	logic [VAR_W-1:0] kq_q;
	logic [COS_W-1:0] crm_q;
	logic [COS_W-1:0] cpm_q;
	logic             tneg_q;
	logic [PM_W-1:0]  pm_q;
	logic [VAR_W:0]   m2_q;
	logic [HGT_W-1:0] mag_q;
	logic             dneg_q;
	logic [HGT_W-1:0] accd_q;
	logic             rnd_q;
	logic [VAR_W:0]   accv_q;
	logic [HGT_W-1:0] xs_q;
	logic [PM_W-1:0]  acct_q;

	// result register
	logic                     out_valid_q;
	logic [HGT_W-1:0]         out_fh_q;
	logic signed [TILT_W-1:0] out_th_q;
	logic                     out_oor_q;

	logic cfg_wr;
	logic accept;

	// step logic
	logic [VAR_W+1:0] rem_sh;
	logic             k_ge;
	logic [VAR_W:0]   rem_nx;
	logic [HGT_W:0]   z_t;
	logic             z_ge;
	logic [HGT_W-1:0] z_hi;
	logic [PM_W-1:0]  pm_nx;
	logic [HGT_W:0]   d_sum;
	logic [VAR_W+1:0] v_sum;
	logic [PM_W:0]    t_sum;
	logic [COS_W-1:0] crm;
	logic [COS_W-1:0] cpm;
	logic [VAR_W:0]   p1_sum;
	logic [VAR_W-1:0] p1_sat;
	logic [NUM_W-1:0] z_num;
	logic [HGT_W-1:0] z_sel;
	logic             z_lt;
	logic [VAR_W-1:0] k_fix;
	logic [HGT_W:0]   delta;
	logic [HGT_W+1:0] x_sum;
	logic [HGT_W-1:0] x_new;
	logic [TR_W-1:0]  t_raw;
	logic [HGT_W-1:0] t_mag;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= erkf_pkg::TIMEOUT_RST;
			maxh_q    <= erkf_pkg::MAXH_RST;
			pvar_q    <= erkf_pkg::PVAR_RST;
			mvar_q    <= erkf_pkg::MVAR_RST;
		end else if (cfg_wr) begin
			unique case (erkf_pkg::reg_idx_t'(paddr[erkf_pkg::ADDR_W-1:2]))
				erkf_pkg::REG_TIMEOUT: timeout_q <= pwdata[TMO_W-1:0];
				erkf_pkg::REG_MAXH:    maxh_q    <= pwdata[HGT_W-1:0];
				erkf_pkg::REG_PVAR:    pvar_q    <= pwdata[VAR_W-1:0];
				erkf_pkg::REG_MVAR:    mvar_q    <= pwdata[VAR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (erkf_pkg::reg_idx_t'(paddr[erkf_pkg::ADDR_W-1:2]))
			erkf_pkg::REG_TIMEOUT: prdata = erkf_pkg::DATA_W'(timeout_q);
			erkf_pkg::REG_MAXH:    prdata = erkf_pkg::DATA_W'(maxh_q);
			erkf_pkg::REG_PVAR:    prdata = erkf_pkg::DATA_W'(pvar_q);
			erkf_pkg::REG_MVAR:    prdata = erkf_pkg::DATA_W'(mvar_q);
			default:               prdata = '0;
		endcase
	end

	assign echo.ready = (state_q == ST_IDLE);
	assign accept     = echo.valid & echo.ready;

	assign height.valid           = out_valid_q;
	assign height.filtered_height = out_fh_q;
	assign height.tilted_height   = out_th_q;
	assign height.out_of_range    = out_oor_q;

	always_comb begin
		// cosine magnitudes; the most negative code maps to 2^15
		crm = echo.cos_roll[COS_W-1]  ? COS_W'(~echo.cos_roll + 1'b1)  : echo.cos_roll;
		cpm = echo.cos_pitch[COS_W-1] ? COS_W'(~echo.cos_pitch + 1'b1) : echo.cos_pitch;

		p1_sum = {1'b0, var_q} + {1'b0, pvar_q};
		p1_sat = p1_sum[VAR_W] ? '1 : p1_sum[VAR_W-1:0];

		z_num = NUM_W'(width_q[TMO_W-1:0]) * NUM_W'(erkf_pkg::SPEED_Q) + erkf_pkg::Z_ROUND;

		// gain: one restoring division step per cycle
		rem_sh = {rem_q, 1'b0};
		k_ge   = (rem_sh >= {1'b0, den_q});
		rem_nx = k_ge ? (VAR_W+1)'(rem_sh - {1'b0, den_q}) : rem_sh[VAR_W:0];

		// height quotient: remainder sits above the dividend bits
		z_t  = zn_q[NUM_W-1:HGT_W-1];
		z_ge = (z_t >= {1'b0, erkf_pkg::Z_DIV});
		z_hi = z_ge ? HGT_W'(z_t - {1'b0, erkf_pkg::Z_DIV}) : z_t[HGT_W-1:0];

		// cosine product, most significant bit first
		pm_nx = {pm_q[PM_W-2:0], 1'b0} + (cpm_q[COS_W-1] ? PM_W'(crm_q) : '0);

		// shift-right multipliers, least significant multiplier bit first
		d_sum = {1'b0, accd_q} + (kq_q[0] ? {1'b0, mag_q} : '0);
		v_sum = {1'b0, accv_q} + (p1_q[0] ? {1'b0, m2_q} : '0);
		t_sum = {1'b0, acct_q} + (xs_q[0] ? {1'b0, pm_q} : '0);

		z_sel = oor_q ? maxh_q : zn_q[HGT_W-1:0];
		z_lt  = (z_sel < x_q);
		k_fix = (den_q == '0) ? '0 : kq_q;

		delta = {1'b0, accd_q} + (HGT_W+1)'(rnd_q);
		x_sum = {2'b0, x_q} + {1'b0, delta};
		if (dneg_q) begin
			x_new = (delta > {1'b0, x_q}) ? '0 : HGT_W'({1'b0, x_q} - delta);
		end else begin
			x_new = (x_sum > (HGT_W+2)'(erkf_pkg::HGT_MAX)) ? erkf_pkg::HGT_MAX
			                                                 : x_sum[HGT_W-1:0];
		end

		// round half up on the bit below the kept field, then saturate
		t_raw = TR_W'(acct_q[PM_W-1:erkf_pkg::TILT_SH])
		      + TR_W'(acct_q[erkf_pkg::TILT_SH-1]);
		t_mag = (t_raw > TR_W'(erkf_pkg::HGT_MAX)) ? erkf_pkg::HGT_MAX
		                                           : t_raw[HGT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rise_q      <= '0;
			x_q         <= '0;
			var_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (height.ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (echo.echo_level) begin
							rise_q <= echo.timestamp_us;
						end else begin
							width_q <= echo.timestamp_us - rise_q;
							p1_q    <= p1_sat;
							crm_q   <= crm;
							cpm_q   <= cpm;
							tneg_q  <= echo.cos_roll[COS_W-1] ^ echo.cos_pitch[COS_W-1];
							pm_q    <= '0;
							state_q <= ST_PREP;
						end
					end
				end
				ST_PREP: begin
					oor_q   <= (width_q > TS_W'(timeout_q));
					zn_q    <= z_num;
					den_q   <= {1'b0, p1_q} + {1'b0, mvar_q};
					rem_q   <= {1'b0, p1_q};
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= rem_nx;
					kq_q  <= {kq_q[VAR_W-2:0], k_ge};
					if (cnt_q < erkf_pkg::Z_STEPS) begin
						zn_q <= {z_hi, zn_q[HGT_W-2:0], z_ge};
					end
					if (cnt_q < erkf_pkg::PM_STEPS) begin
						pm_q  <= pm_nx;
						cpm_q <= {cpm_q[COS_W-2:0], 1'b0};
					end
					if (cnt_q == erkf_pkg::K_LAST) begin
						state_q <= ST_SETUP;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SETUP: begin
					kq_q    <= k_fix;
					m2_q    <= {1'b1, {VAR_W{1'b0}}} - {1'b0, k_fix};
					dneg_q  <= z_lt;
					mag_q   <= z_lt ? HGT_W'(x_q - z_sel) : HGT_W'(z_sel - x_q);
					accd_q  <= '0;
					rnd_q   <= 1'b0;
					accv_q  <= '0;
					cnt_q   <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					accd_q <= d_sum[HGT_W:1];
					rnd_q  <= d_sum[0];
					kq_q   <= {1'b0, kq_q[VAR_W-1:1]};
					accv_q <= v_sum[VAR_W+1:1];
					p1_q   <= {1'b0, p1_q[VAR_W-1:1]};
					if (cnt_q == erkf_pkg::K_LAST) begin
						state_q <= ST_UPD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_UPD: begin
					x_q     <= x_new;
					xs_q    <= x_new;
					var_q   <= accv_q[VAR_W-1:0];
					acct_q  <= '0;
					cnt_q   <= '0;
					state_q <= ST_TILT;
				end
				ST_TILT: begin
					acct_q <= t_sum[PM_W:1];
					xs_q   <= {1'b0, xs_q[HGT_W-1:1]};
					if (cnt_q == erkf_pkg::T_LAST) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					// hold until the result register is free or being emptied
					if (!out_valid_q || height.ready) begin
						out_valid_q <= 1'b1;
						out_fh_q    <= x_q;
						out_th_q    <= tneg_q ? TILT_W'(-$signed({1'b0, t_mag}))
						                      : TILT_W'($signed({1'b0, t_mag}));
						out_oor_q   <= oor_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ tb/sv/echo_range_kalman_filter_unit_tb.sv @@
// Self-checking bench for the echo range Kalman filter: edge stimulus, height prediction, APB set-up.
`timescale 1ns / 1ps

module echo_range_kalman_filter_unit_tb;
	import erkf_pkg::*;

	localparam logic LVL_RISE = 1'b1;
	localparam logic LVL_FALL = 1'b0;

	localparam logic [63:0] SPEED_NUM  = 64'd11141120;
	localparam logic [63:0] SPEED_DEN  = 64'd1000000;
	localparam logic [63:0] HEIGHT_LIM = 64'd1048575;
	localparam logic [63:0] TILT_LIM   = 64'd1048575;

	localparam int SETTLE_CYCLES   = 100;
	localparam int HOLD_CYCLES     = 1000;
	localparam int ITEMS_PER_PHASE = 310;
	localparam int RANDOM_PHASES   = 6;

	typedef struct {
		logic                    level;
		logic [TS_W-1:0]         ts;
		logic signed [COS_W-1:0] cos_roll;
		logic signed [COS_W-1:0] cos_pitch;
	} echo_item_t;

	typedef struct {
		logic [HGT_W-1:0]         filtered;
		logic signed [TILT_W-1:0] tilted;
		logic                     oor;
	} height_res_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	erkf_echo_if   echo_ch ();
	erkf_height_if height_ch ();

	echo_range_kalman_filter_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.echo    (echo_ch),
		.height  (height_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #2 clk = ~clk;

	// predictor state and register shadows
	logic [TS_W-1:0]  rise_ts     = '0;
	logic [HGT_W-1:0] est_height  = '0;
	logic [VAR_W-1:0] est_var     = '0;
	logic [TMO_W-1:0] cfg_timeout = TIMEOUT_RST;
	logic [HGT_W-1:0] cfg_maxh    = MAXH_RST;
	logic [VAR_W-1:0] cfg_pvar    = PVAR_RST;
	logic [VAR_W-1:0] cfg_mvar    = MVAR_RST;

	echo_item_t  edge_backlog[$];
	height_res_t height_due_q[$];
	echo_item_t  on_bus;
	height_res_t due;

	int unsigned n_queued    = 0;
	int unsigned n_accepted  = 0;
	int unsigned mismatches  = 0;
	int unsigned tx_idle_pct = 8;
	int unsigned rx_idle_pct = 52;
	int unsigned hold_left   = 0;
	logic        hold_go;
	logic [TS_W-1:0] us_now  = 32'h0000_1000;

	task automatic predict_height(input echo_item_t it);
		logic [TS_W-1:0]    width;
		logic [63:0]        z, p1, den, rem, gain, mag, delta, x, prod_mag;
		logic [95:0]        var_prod;
		logic signed [31:0] cos_prod;
		logic               over, neg;
		int                 i;
		height_res_t        res;
		if (it.level == LVL_RISE) begin
			rise_ts = it.ts;
			return;
		end
		width = it.ts - rise_ts;
		over = width > cfg_timeout;
		if (over) begin
			z = 64'(cfg_maxh);
		end else begin
			z = (64'(width) * SPEED_NUM + SPEED_DEN / 2) / SPEED_DEN;
			if (z > HEIGHT_LIM)
				z = HEIGHT_LIM;
		end
		p1 = 64'(est_var) + 64'(cfg_pvar);
		if (p1 > 64'hFFFF_FFFF)
			p1 = 64'hFFFF_FFFF;
		den = p1 + 64'(cfg_mvar);
		// restoring long division for a 32-bit fractional gain
		gain = '0;
		if (den != 0) begin
			rem = p1;
			for (i = 0; i < 32; i++) begin
				rem = rem << 1;
				gain = gain << 1;
				if (rem >= den) begin
					rem = rem - den;
					gain[0] = 1'b1;
				end
			end
		end
		x = 64'(est_height);
		neg = z < x;
		mag = neg ? x - z : z - x;
		delta = (mag * gain + 64'h8000_0000) >> 32;
		if (neg) begin
			x = (delta > x) ? 64'd0 : x - delta;
		end else begin
			x = x + delta;
			if (x > HEIGHT_LIM)
				x = HEIGHT_LIM;
		end
		est_height = x[HGT_W-1:0];
		var_prod = ((96'd1 << 32) - 96'(gain)) * 96'(p1);
		est_var = var_prod[63:32];
		cos_prod = it.cos_roll * it.cos_pitch;
		neg = cos_prod < 0;
		prod_mag = neg ? 64'(-cos_prod) : 64'(cos_prod);
		mag = (x * prod_mag + (64'd1 << 27)) >> 28;
		if (mag > TILT_LIM)
			mag = TILT_LIM;
		res.filtered = x[HGT_W-1:0];
		res.tilted = neg ? -mag[TILT_W-1:0] : mag[TILT_W-1:0];
		res.oor = over;
		height_due_q.push_back(res);
	endtask

	function automatic logic signed [COS_W-1:0] pick_cos();
		if ($urandom_range(99) < 85)
			return COS_W'(int'($urandom_range(32768)) - 16384);
		return COS_W'($urandom);
	endfunction

	function automatic logic [TS_W-1:0] pick_width();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 65)
			return $urandom_range(32'(cfg_timeout));
		if (sel < 75)
			return 32'(cfg_timeout) + $urandom_range(1);
		if (sel < 90)
			return 32'(cfg_timeout) + $urandom_range(20000, 2);
		return $urandom;
	endfunction

	task automatic send_edge(input logic lvl, input logic [TS_W-1:0] ts,
			input logic signed [COS_W-1:0] cr, input logic signed [COS_W-1:0] cp);
		echo_item_t it;
		it.level = lvl;
		it.ts = ts;
		it.cos_roll = cr;
		it.cos_pitch = cp;
		edge_backlog.push_back(it);
		n_queued++;
	endtask

	task automatic send_pulse(input logic [TS_W-1:0] width,
			input logic signed [COS_W-1:0] cr, input logic signed [COS_W-1:0] cp);
		send_edge(LVL_RISE, us_now, pick_cos(), pick_cos());
		send_edge(LVL_FALL, us_now + width, cr, cp);
		us_now = us_now + width + $urandom_range(40000, 1);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_TIMEOUT: cfg_timeout = val[TMO_W-1:0];
			REG_MAXH:    cfg_maxh = val[HGT_W-1:0];
			REG_PVAR:    cfg_pvar = val[VAR_W-1:0];
			REG_MVAR:    cfg_mvar = val[VAR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (n_accepted != n_queued || height_due_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// echo driver: hold the item until its transfer, then advance
	always @(posedge clk) begin
		if (!arst_n) begin
			echo_ch.valid <= 1'b0;
		end else begin
			if (echo_ch.valid && echo_ch.ready) begin
				predict_height(on_bus);
				n_accepted++;
			end
			if (!echo_ch.valid || echo_ch.ready) begin
				if (edge_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					on_bus = edge_backlog.pop_front();
					echo_ch.valid <= 1'b1;
					echo_ch.echo_level <= on_bus.level;
					echo_ch.timestamp_us <= on_bus.ts;
					echo_ch.cos_roll <= on_bus.cos_roll;
					echo_ch.cos_pitch <= on_bus.cos_pitch;
				end else begin
					echo_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_go)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// height monitor and receiver back-pressure
	always @(posedge clk) begin
		if (!arst_n) begin
			height_ch.ready <= 1'b0;
		end else begin
			if (height_ch.valid && height_ch.ready) begin
				if (height_due_q.size() == 0) begin
					$error("height transfer with nothing predicted: filtered_height %0d",
						height_ch.filtered_height);
					mismatches++;
				end else begin
					due = height_due_q.pop_front();
					if (height_ch.filtered_height !== due.filtered) begin
						$error("filtered_height: expected %0d, got %0d",
							due.filtered, height_ch.filtered_height);
						mismatches++;
					end
					if (height_ch.tilted_height !== due.tilted) begin
						$error("tilted_height: expected %0d, got %0d",
							due.tilted, height_ch.tilted_height);
						mismatches++;
					end
					if (height_ch.out_of_range !== due.oor) begin
						$error("out_of_range: expected %0d, got %0d",
							due.oor, height_ch.out_of_range);
						mismatches++;
					end
				end
			end
			height_ch.ready <= !hold_go && hold_left <= 1
				&& $urandom_range(99) >= rx_idle_pct;
		end
	end

	initial begin
		int          ph;
		int          sent;
		int unsigned pick;
		echo_ch.valid = 1'b0;
		echo_ch.echo_level = 1'b0;
		echo_ch.timestamp_us = '0;
		echo_ch.cos_roll = '0;
		echo_ch.cos_pitch = '0;
		height_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		hold_go = 1'b0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: fall with no prior rise, wrap, zero width, timeout boundary
		send_edge(LVL_FALL, 32'd1000, 16'sd16384, 16'sd16384);
		send_edge(LVL_RISE, 32'hFFFF_FF00, 16'sd16384, 16'sd16384);
		send_edge(LVL_FALL, 32'h0000_0100, -16'sd16384, 16'sd16384);
		send_edge(LVL_RISE, 32'd5000, 16'sd0, 16'sd0);
		send_edge(LVL_FALL, 32'd5000, -16'sd16384, -16'sd16384);
		send_pulse(32'd30000, 16'sd0, 16'sd16384);
		send_pulse(32'd30001, -16'sd32768, -16'sd32768);
		// second fall on the same rise
		send_edge(LVL_FALL, 32'hFFFF_FFFF, 16'sd32767, -16'sd32768);
		send_edge(LVL_RISE, 32'h0000_0000, 16'sd1, -16'sd1);
		send_edge(LVL_RISE, 32'd100, 16'sd5000, 16'sd9000);
		send_edge(LVL_FALL, 32'd20100, 16'sd16384, 16'sd16384);
		send_edge(LVL_RISE, 32'hFFFF_FFFF, -16'sd1, 16'sd12000);
		send_edge(LVL_FALL, 32'hFFFF_FFFE, 16'sd16000, -16'sd8000);
		wait_drained();

		// widest timeout, top height, saturating variance and gain
		write_reg(REG_TIMEOUT, 32'h0000_FFFF);
		write_reg(REG_MAXH, 32'h000F_FFFF);
		write_reg(REG_PVAR, 32'hFFFF_FFFF);
		write_reg(REG_MVAR, 32'h0000_0000);
		send_pulse(32'd65535, -16'sd32768, -16'sd32768);
		send_pulse(32'd65536, -16'sd32768, 16'sd32767);
		send_pulse(32'd65536, 16'sd16384, 16'sd16384);
		wait_drained();

		// everything zero: the gain denominator vanishes
		write_reg(REG_TIMEOUT, 32'h0000_0000);
		write_reg(REG_MAXH, 32'h0000_0000);
		write_reg(REG_PVAR, 32'h0000_0000);
		write_reg(REG_MVAR, 32'h0000_0000);
		send_pulse(32'd0, 16'sd16384, -16'sd16384);
		send_pulse(32'd1, 16'sd0, 16'sd0);
		wait_drained();

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph < 2) begin
				tx_idle_pct = 8;
				rx_idle_pct = 52;
			end else if (ph < 4) begin
				tx_idle_pct = 52;
				rx_idle_pct = 8;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			if (ph == RANDOM_PHASES - 1) begin
				write_reg(REG_TIMEOUT, 32'(TIMEOUT_RST));
				write_reg(REG_MAXH, 32'(MAXH_RST));
				write_reg(REG_PVAR, PVAR_RST);
				write_reg(REG_MVAR, MVAR_RST);
			end else begin
				write_reg(REG_TIMEOUT, {16'($urandom), 16'($urandom_range(65535, 500))});
				write_reg(REG_MAXH, $urandom);
				write_reg(REG_PVAR, ($urandom_range(1) != 0) ? $urandom
					: $urandom_range(1 << 22));
				write_reg(REG_MVAR, ($urandom_range(1) != 0) ? $urandom
					: $urandom_range(1 << 22));
			end
			// long receiver stall while edges keep coming: fill the block up
			if (ph == 2) begin
				@(posedge clk);
				hold_go <= 1'b1;
				@(posedge clk);
				hold_go <= 1'b0;
			end
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				pick = $urandom_range(99);
				if (pick < 80) begin
					send_pulse(pick_width(), pick_cos(), pick_cos());
					sent += 2;
				end else if (pick < 88) begin
					send_edge(LVL_FALL, $urandom, pick_cos(), pick_cos());
					sent++;
				end else if (pick < 94) begin
					send_edge(LVL_RISE, $urandom, pick_cos(), pick_cos());
					sent++;
				end else begin
					send_edge(LVL_RISE, $urandom, pick_cos(), pick_cos());
					send_edge(LVL_FALL, $urandom, pick_cos(), pick_cos());
					sent += 2;
				end
			end
			wait_drained();
		end

		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
